[src/plmc_pkg.sv]
package plmc_pkg;

    localparam int unsigned CntWidth = 16;

    typedef logic [CntWidth-1:0] cnt_t;

    localparam cnt_t CntMax = '1;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_NEAR_THRESHOLD    = 2'd0,
        REG_HOLD_TIME         = 2'd1,
        REG_RUN_LIMIT         = 2'd2,
        REG_BLINK_HALF_PERIOD = 2'd3
    } reg_index_t;

    localparam cnt_t NearThresholdReset   = 16'd800;
    localparam cnt_t HoldTimeReset        = 16'd10000;
    localparam cnt_t RunLimitReset        = 16'd1500;
    localparam cnt_t BlinkHalfPeriodReset = 16'd500;
    localparam cnt_t SlotReset            = 16'd1000;

    typedef enum logic [1:0] {
        MOVE_IDLE = 2'd0,
        MOVE_UP   = 2'd1,
        MOVE_STOP = 2'd2,
        MOVE_DOWN = 2'd3
    } move_t;

    function automatic cnt_t sat_inc(input cnt_t v);
        sat_inc = (v == CntMax) ? v : v + cnt_t'(1);
    endfunction

    // median of three by clamping c between min and max of a and b
    function automatic cnt_t median3(input cnt_t a, input cnt_t b, input cnt_t c);
        cnt_t lo;
        cnt_t hi;
        lo = (a <= b) ? a : b;
        hi = (a <= b) ? b : a;
        if (c < lo)
            median3 = lo;
        else if (c > hi)
            median3 = hi;
        else
            median3 = c;
    endfunction

endpackage

[src/proximity_lid_motor_controller_core.sv]
// Each item passes the input register, then the result register, which offers its result.
// Throughput: one item per cycle while out_stall is low; controller state advances once per item.
// The result register frees itself while being taken, so a stalled output holds one result
// and one more item waits in the input register before in_stall rises.
// Reset (rst_n low, asynchronous): pipeline empty, configuration and state back to power-up values.
module proximity_lid_motor_controller_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  sample_valid,
    input  logic [15:0]           range_mm,
    input  logic                  top_switch_pressed,
    input  logic                  bottom_switch_pressed,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  relay_raise,
    output logic                  relay_lower,
    output logic                  led_on,
    output logic                  protected_res,
    output logic                  want_open
);

    // configuration
    plmc_pkg::cnt_t near_threshold_reg;
    plmc_pkg::cnt_t hold_time_reg;
    plmc_pkg::cnt_t run_limit_reg;
    plmc_pkg::cnt_t blink_half_period_reg;

    // input stage
    logic           s1_valid_reg;
    logic           s1_sample_reg;
    plmc_pkg::cnt_t s1_range_reg;
    logic           s1_top_reg;
    logic           s1_bottom_reg;

    // controller state
    plmc_pkg::cnt_t slot0_reg, slot1_reg, slot2_reg;
    logic [1:0]     slot_ptr_reg;
    logic           wish_reg;
    plmc_pkg::cnt_t since_near_reg;
    logic           raise_on_reg, lower_on_reg;
    logic           raise_timing_reg, lower_timing_reg;
    plmc_pkg::cnt_t raise_run_reg, lower_run_reg;
    logic           protect_reg;
    logic           led_reg;
    plmc_pkg::cnt_t blink_reg;
    logic [1:0]     prev_sw_reg;

    // result stage
    logic out_valid_reg;
    logic out_raise_reg, out_lower_reg, out_led_reg, out_protect_reg, out_wish_reg;

    // next values
    plmc_pkg::cnt_t slot0_next, slot1_next, slot2_next;
    logic [1:0]     slot_ptr_next;
    logic           wish_next;
    plmc_pkg::cnt_t since_near_next;
    logic           raise_on_next, lower_on_next;
    logic           raise_timing_next, lower_timing_next;
    plmc_pkg::cnt_t raise_run_next, lower_run_next;
    logic           protect_next;
    logic           led_next;
    plmc_pkg::cnt_t blink_next;
    logic [1:0]     sw_now;

    logic out_load;
    logic s1_advance;
    logic s1_load;

    assign out_load   = !out_valid_reg || !out_stall;
    assign s1_advance = s1_valid_reg && out_load;
    assign s1_load    = !s1_valid_reg || out_load;
    assign in_stall   = !s1_load;

    assign sw_now = {s1_bottom_reg, s1_top_reg};

    always_comb
    begin
        plmc_pkg::move_t move;
        plmc_pkg::cnt_t  median;
        logic            new_press;

        slot0_next        = slot0_reg;
        slot1_next        = slot1_reg;
        slot2_next        = slot2_reg;
        slot_ptr_next     = slot_ptr_reg;
        wish_next         = wish_reg;
        since_near_next   = plmc_pkg::sat_inc(since_near_reg);
        blink_next        = plmc_pkg::sat_inc(blink_reg);
        raise_run_next    = raise_timing_reg ? plmc_pkg::sat_inc(raise_run_reg) : raise_run_reg;
        lower_run_next    = lower_timing_reg ? plmc_pkg::sat_inc(lower_run_reg) : lower_run_reg;
        raise_on_next     = raise_on_reg;
        lower_on_next     = lower_on_reg;
        raise_timing_next = raise_timing_reg;
        lower_timing_next = lower_timing_reg;
        protect_next      = protect_reg;
        led_next          = led_reg;
        move              = plmc_pkg::MOVE_IDLE;
        median            = '0;

        // a switch that has just been pressed clears both relays; the switch case below may start a new move
        new_press = |(sw_now & ~prev_sw_reg);
        if (new_press)
        begin
            raise_on_next = 1'b0;
            lower_on_next = 1'b0;
            move          = plmc_pkg::MOVE_STOP;
        end

        if (s1_sample_reg)
        begin
            slot_ptr_next = (slot_ptr_reg >= 2'd2) ? 2'd0 : slot_ptr_reg + 2'd1;
            unique case (slot_ptr_next)
                2'd0:    slot0_next = s1_range_reg;
                2'd1:    slot1_next = s1_range_reg;
                default: slot2_next = s1_range_reg;
            endcase
            if (slot_ptr_next == 2'd2)
            begin
                median = plmc_pkg::median3(slot0_reg, slot1_reg, s1_range_reg);
                if (median < near_threshold_reg)
                begin
                    since_near_next = '0;
                    wish_next       = 1'b1;
                end
                else if (wish_reg && since_near_next > hold_time_reg)
                begin
                    wish_next = 1'b0;
                end
            end
        end

        case (sw_now)
            2'b00:
            begin
                if (wish_next && !raise_on_next)
                    move = plmc_pkg::MOVE_UP;
            end
            2'b01:   move = wish_next ? plmc_pkg::MOVE_STOP : plmc_pkg::MOVE_DOWN;
            2'b10:   move = wish_next ? plmc_pkg::MOVE_UP : plmc_pkg::MOVE_STOP;
            default: ;
        endcase

        unique case (move)
            plmc_pkg::MOVE_UP:
            begin
                if (!protect_reg)
                    raise_on_next = 1'b1;
                lower_on_next = 1'b0;
            end
            plmc_pkg::MOVE_STOP:
            begin
                raise_on_next = 1'b0;
                lower_on_next = 1'b0;
            end
            plmc_pkg::MOVE_DOWN:
            begin
                raise_on_next = 1'b0;
                if (!protect_reg)
                    lower_on_next = 1'b1;
            end
            default: ;
        endcase

        // run timers: raise checked first, then lower
        if (raise_on_next && !raise_timing_reg)
            raise_run_next = '0;
        raise_timing_next = raise_on_next;
        if (raise_timing_next && raise_run_next > run_limit_reg)
        begin
            raise_timing_next = 1'b0;
            raise_on_next     = 1'b0;
            lower_on_next     = 1'b0;
            protect_next      = 1'b1;
        end

        if (lower_on_next && !lower_timing_reg)
            lower_run_next = '0;
        lower_timing_next = lower_on_next;
        if (lower_timing_next && lower_run_next > run_limit_reg)
        begin
            lower_timing_next = 1'b0;
            raise_on_next     = 1'b0;
            lower_on_next     = 1'b0;
            protect_next      = 1'b1;
        end

        if (protect_next && blink_next > blink_half_period_reg)
        begin
            blink_next = '0;
            led_next   = !led_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_threshold_reg    <= plmc_pkg::NearThresholdReset;
            hold_time_reg         <= plmc_pkg::HoldTimeReset;
            run_limit_reg         <= plmc_pkg::RunLimitReset;
            blink_half_period_reg <= plmc_pkg::BlinkHalfPeriodReset;
        end
        else if (cfg_write)
        begin
            unique case (plmc_pkg::reg_index_t'(cfg_index))
                plmc_pkg::REG_NEAR_THRESHOLD:    near_threshold_reg    <= cfg_data;
                plmc_pkg::REG_HOLD_TIME:         hold_time_reg         <= cfg_data;
                plmc_pkg::REG_RUN_LIMIT:         run_limit_reg         <= cfg_data;
                plmc_pkg::REG_BLINK_HALF_PERIOD: blink_half_period_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_load)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && in_valid)
        begin
            s1_sample_reg <= sample_valid;
            s1_range_reg  <= range_mm;
            s1_top_reg    <= top_switch_pressed;
            s1_bottom_reg <= bottom_switch_pressed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot0_reg        <= plmc_pkg::SlotReset;
            slot1_reg        <= plmc_pkg::SlotReset;
            slot2_reg        <= plmc_pkg::SlotReset;
            slot_ptr_reg     <= 2'd0;
            wish_reg         <= 1'b0;
            since_near_reg   <= '0;
            raise_on_reg     <= 1'b0;
            lower_on_reg     <= 1'b0;
            raise_timing_reg <= 1'b0;
            lower_timing_reg <= 1'b0;
            raise_run_reg    <= '0;
            lower_run_reg    <= '0;
            protect_reg      <= 1'b0;
            led_reg          <= 1'b0;
            blink_reg        <= '0;
            prev_sw_reg      <= 2'b00;
        end
        else if (s1_advance)
        begin
            slot0_reg        <= slot0_next;
            slot1_reg        <= slot1_next;
            slot2_reg        <= slot2_next;
            slot_ptr_reg     <= slot_ptr_next;
            wish_reg         <= wish_next;
            since_near_reg   <= since_near_next;
            raise_on_reg     <= raise_on_next;
            lower_on_reg     <= lower_on_next;
            raise_timing_reg <= raise_timing_next;
            lower_timing_reg <= lower_timing_next;
            raise_run_reg    <= raise_run_next;
            lower_run_reg    <= lower_run_next;
            protect_reg      <= protect_next;
            led_reg          <= led_next;
            blink_reg        <= blink_next;
            prev_sw_reg      <= sw_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_raise_reg   <= raise_on_next;
            out_lower_reg   <= lower_on_next;
            out_led_reg     <= led_next;
            out_protect_reg <= protect_next;
            out_wish_reg    <= wish_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign relay_raise   = out_raise_reg;
    assign relay_lower   = out_lower_reg;
    assign led_on        = out_led_reg;
    assign protected_res = out_protect_reg;
    assign want_open     = out_wish_reg;

    // protection is a latch: only reset clears it
    assert property (@(posedge clk) disable iff (!rst_n) protect_reg |=> protect_reg)
        else $error("protection latch cleared");

    // the two relays are never driven together
    assert property (@(posedge clk) disable iff (!rst_n)
        !(raise_on_reg && lower_on_reg))
        else $error("both relays on");

    // back-pressure only when both stages hold an item
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled with room in the pipeline");

    // the slot pointer walks 0..2 only
    assert property (@(posedge clk) disable iff (!rst_n) slot_ptr_reg != 2'd3)
        else $error("slot pointer out of range");

endmodule
